// ===== design/ecr_pkg.sv =====
// ecr_pkg: stage indexes, widths, context type and output helpers
// for the contact response pipeline; no dependencies
`default_nettype none

package ecr_pkg;

    // field widths
    localparam int MASS_W = 24;
    localparam int DEN_W  = MASS_W + 1;
    localparam int DIV_W  = 60;

    // stage indexes: six front stages, one divider stage per quotient bit, two back stages
    localparam int DIV_BASE = 5;
    localparam int P1_IDX   = DIV_BASE + DIV_W + 1;
    localparam int OUT_IDX  = P1_IDX + 1;
    localparam int NUM_STG  = OUT_IDX + 1;

    localparam logic [MASS_W-1:0] MASS_INF  = '1;
    // velocity quotients at or above this always saturate once scaled by a nonzero normal component
    localparam logic [46:0]       DA_CLAMP  = 47'h4000_0000_0000;

    // per-item context carried alongside the divider lanes
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [15:0]      ax_mag;
        logic [15:0]      ay_mag;
        logic             ax_neg;
        logic             ay_neg;
        logic             va_neg;
        logic             vb_neg;
        logic [31:0]      tx;
        logic [31:0]      ty;
        logic             kill_all;
        logic             kill_shift;
    } ecr_ctx_t;

    // round a scaled velocity product by 2^14, apply sign, saturate; zero on kill
    function automatic logic [31:0] ecr_dvel(input logic [62:0] prod, input logic neg,
                                             input logic kill);
        logic [63:0] sum;
        logic [49:0] mag;
        logic [31:0] res;
        sum = 64'(prod) + 64'd8192;
        mag = sum[63:14];
        if (kill) begin
            res = '0;
        end else if (!neg) begin
            res = (mag > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            res = (mag > 50'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        end
        return res;
    endfunction

    // integer displacement from a Q.16 share: truncate, push a nonzero result one unit out, sign; zero on kill
    function automatic logic [31:0] ecr_shift(input logic [31:0] q, input logic neg,
                                              input logic kill);
        logic [16:0] mag;
        logic [31:0] res;
        mag = {1'b0, q[31:16]};
        if (mag != '0) begin
            mag = mag + 17'd1;
        end
        if (kill) begin
            res = '0;
        end else if (neg) begin
            res = ~(32'(mag)) + 32'd1;
        end else begin
            res = 32'(mag);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/elastic_contact_response.sv =====
// elastic_contact_response: pipelined two-body contact solver
// uses ecr_pkg for stage indexes, context type and output helpers
`default_nettype none

//  channel | ports                  | direction | notes
//  --------+------------------------+-----------+------------------------------
//  s_      | s_valid/s_ready + 11   | in        | one contact per item
//  m_      | m_valid/m_ready + 8    | out       | velocity changes, displacements
//
// one item per cycle sustained while m_ready is not held low; stages: 6 front, 60 divider, 2 back
// the 60 bit restoring divider, one quotient bit per stage, sets the depth
// every stage has its own valid bit and advances when the stage after it is free,
// so bubbles close up and a stalled output keeps accepting until the pipe is full
// aresetn (synchronous, active low) clears only the valid bits

module elastic_contact_response (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [23:0]        s_mass_a,
    input  wire logic [23:0]        s_mass_b,
    input  wire logic signed [31:0] s_vel_a_x,
    input  wire logic signed [31:0] s_vel_a_y,
    input  wire logic signed [31:0] s_vel_b_x,
    input  wire logic signed [31:0] s_vel_b_y,
    input  wire logic signed [31:0] s_center_offset_x,
    input  wire logic signed [31:0] s_center_offset_y,
    input  wire logic signed [15:0] s_normal_x,
    input  wire logic signed [15:0] s_normal_y,
    input  wire logic [30:0]        s_overlap_depth,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_dvel_a_x,
    output logic signed [31:0]      m_dvel_a_y,
    output logic signed [31:0]      m_dvel_b_x,
    output logic signed [31:0]      m_dvel_b_y,
    output logic signed [31:0]      m_shift_a_x,
    output logic signed [31:0]      m_shift_a_y,
    output logic signed [31:0]      m_shift_b_x,
    output logic signed [31:0]      m_shift_b_y
);

    localparam int DW = ecr_pkg::DIV_W;
    localparam int DB = ecr_pkg::DIV_BASE;

    // stage valid bits and per-stage advance
    logic [ecr_pkg::NUM_STG-1:0] v_reg;
    logic [ecr_pkg::NUM_STG-1:0] stg_rdy;

    always_comb begin
        stg_rdy[ecr_pkg::OUT_IDX] = !v_reg[ecr_pkg::OUT_IDX] || m_ready;
        for (int i = ecr_pkg::OUT_IDX - 1; i >= 0; i--) begin
            stg_rdy[i] = !v_reg[i] || stg_rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (stg_rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < ecr_pkg::NUM_STG; i++) begin
                if (stg_rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stg_rdy[0];
    assign m_valid = v_reg[ecr_pkg::OUT_IDX];

    // ---------------- stage 1: raw products
    logic [15:0]        nx_mag, ny_mag;
    logic signed [47:0] f1_so_x_reg, f1_so_y_reg;
    logic signed [47:0] f1_pax_reg, f1_pay_reg, f1_pbx_reg, f1_pby_reg;
    logic [46:0]        f1_dep_x_reg, f1_dep_y_reg;
    logic [23:0]        f1_ma_reg, f1_mb_reg;
    logic [15:0]        f1_nx_mag_reg, f1_ny_mag_reg;
    logic               f1_nx_neg_reg, f1_ny_neg_reg, f1_nx_nz_reg, f1_ny_nz_reg;

    assign nx_mag = s_normal_x[15] ? 16'(-s_normal_x) : 16'(s_normal_x);
    assign ny_mag = s_normal_y[15] ? 16'(-s_normal_y) : 16'(s_normal_y);

    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            f1_so_x_reg   <= 48'(s_center_offset_x) * 48'(s_normal_x);
            f1_so_y_reg   <= 48'(s_center_offset_y) * 48'(s_normal_y);
            f1_pax_reg    <= 48'(s_vel_a_x) * 48'(s_normal_x);
            f1_pay_reg    <= 48'(s_vel_a_y) * 48'(s_normal_y);
            f1_pbx_reg    <= 48'(s_vel_b_x) * 48'(s_normal_x);
            f1_pby_reg    <= 48'(s_vel_b_y) * 48'(s_normal_y);
            f1_dep_x_reg  <= 47'(nx_mag) * 47'(s_overlap_depth);
            f1_dep_y_reg  <= 47'(ny_mag) * 47'(s_overlap_depth);
            f1_ma_reg     <= s_mass_a;
            f1_mb_reg     <= s_mass_b;
            f1_nx_mag_reg <= nx_mag;
            f1_ny_mag_reg <= ny_mag;
            f1_nx_neg_reg <= s_normal_x[15];
            f1_ny_neg_reg <= s_normal_y[15];
            f1_nx_nz_reg  <= |s_normal_x;
            f1_ny_nz_reg  <= |s_normal_y;
        end
    end

    // ---------------- stage 2: dot sums, normal orientation, depth scale
    logic signed [48:0] f2_s;
    logic               f2_flip;
    logic signed [48:0] f2_vna_reg, f2_vnb_reg;
    logic               f2_flip_reg;
    logic [31:0]        f2_tx_reg, f2_ty_reg;
    logic               f2_ax_neg_reg, f2_ay_neg_reg;
    logic [15:0]        f2_ax_mag_reg, f2_ay_mag_reg;
    logic [23:0]        f2_ma_reg, f2_mb_reg;
    logic [24:0]        f2_msum_reg;
    logic               f2_infa_reg, f2_infb_reg;

    assign f2_s    = 49'(f1_so_x_reg) + 49'(f1_so_y_reg);
    assign f2_flip = !f2_s[48] && (f2_s != '0);

    always_ff @(posedge aclk) begin
        if (stg_rdy[1]) begin
            f2_vna_reg    <= 49'(f1_pax_reg) + 49'(f1_pay_reg);
            f2_vnb_reg    <= 49'(f1_pbx_reg) + 49'(f1_pby_reg);
            f2_flip_reg   <= f2_flip;
            f2_tx_reg     <= f1_dep_x_reg[45:14];
            f2_ty_reg     <= f1_dep_y_reg[45:14];
            f2_ax_neg_reg <= f2_flip ? (!f1_nx_neg_reg && f1_nx_nz_reg) : f1_nx_neg_reg;
            f2_ay_neg_reg <= f2_flip ? (!f1_ny_neg_reg && f1_ny_nz_reg) : f1_ny_neg_reg;
            f2_ax_mag_reg <= f1_nx_mag_reg;
            f2_ay_mag_reg <= f1_ny_mag_reg;
            f2_ma_reg     <= f1_ma_reg;
            f2_mb_reg     <= f1_mb_reg;
            f2_msum_reg   <= 25'(f1_ma_reg) + 25'(f1_mb_reg);
            f2_infa_reg   <= (f1_ma_reg == ecr_pkg::MASS_INF);
            f2_infb_reg   <= (f1_mb_reg == ecr_pkg::MASS_INF);
        end
    end

    // ---------------- stage 3: round projections to Q.16, ties away from zero
    logic signed [48:0] f3_sa, f3_sb;
    logic signed [34:0] f3_ra_reg, f3_rb_reg;
    logic               f3_flip_reg;
    logic [31:0]        f3_tx_reg, f3_ty_reg;
    logic               f3_ax_neg_reg, f3_ay_neg_reg;
    logic [15:0]        f3_ax_mag_reg, f3_ay_mag_reg;
    logic [23:0]        f3_ma_reg, f3_mb_reg;
    logic [24:0]        f3_msum_reg;
    logic               f3_infa_reg, f3_infb_reg;

    assign f3_sa = f2_vna_reg + (f2_vna_reg[48] ? 49'sd8191 : 49'sd8192);
    assign f3_sb = f2_vnb_reg + (f2_vnb_reg[48] ? 49'sd8191 : 49'sd8192);

    always_ff @(posedge aclk) begin
        if (stg_rdy[2]) begin
            f3_ra_reg     <= f3_sa[48:14];
            f3_rb_reg     <= f3_sb[48:14];
            f3_flip_reg   <= f2_flip_reg;
            f3_tx_reg     <= f2_tx_reg;
            f3_ty_reg     <= f2_ty_reg;
            f3_ax_neg_reg <= f2_ax_neg_reg;
            f3_ay_neg_reg <= f2_ay_neg_reg;
            f3_ax_mag_reg <= f2_ax_mag_reg;
            f3_ay_mag_reg <= f2_ay_mag_reg;
            f3_ma_reg     <= f2_ma_reg;
            f3_mb_reg     <= f2_mb_reg;
            f3_msum_reg   <= f2_msum_reg;
            f3_infa_reg   <= f2_infa_reg;
            f3_infb_reg   <= f2_infb_reg;
        end
    end

    // ---------------- stage 4: oriented projections and their difference
    logic signed [35:0] f4_ra, f4_rb;
    logic signed [35:0] f4_d_reg, f4_pa_reg, f4_pb_reg;
    logic [31:0]        f4_tx_reg, f4_ty_reg;
    logic               f4_ax_neg_reg, f4_ay_neg_reg;
    logic [15:0]        f4_ax_mag_reg, f4_ay_mag_reg;
    logic [23:0]        f4_ma_reg, f4_mb_reg;
    logic [24:0]        f4_msum_reg;
    logic               f4_infa_reg, f4_infb_reg;

    assign f4_ra = 36'(f3_ra_reg);
    assign f4_rb = 36'(f3_rb_reg);

    always_ff @(posedge aclk) begin
        if (stg_rdy[3]) begin
            f4_d_reg      <= f3_flip_reg ? (f4_rb - f4_ra) : (f4_ra - f4_rb);
            f4_pa_reg     <= f3_flip_reg ? -f4_ra : f4_ra;
            f4_pb_reg     <= f3_flip_reg ? -f4_rb : f4_rb;
            f4_tx_reg     <= f3_tx_reg;
            f4_ty_reg     <= f3_ty_reg;
            f4_ax_neg_reg <= f3_ax_neg_reg;
            f4_ay_neg_reg <= f3_ay_neg_reg;
            f4_ax_mag_reg <= f3_ax_mag_reg;
            f4_ay_mag_reg <= f3_ay_mag_reg;
            f4_ma_reg     <= f3_ma_reg;
            f4_mb_reg     <= f3_mb_reg;
            f4_msum_reg   <= f3_msum_reg;
            f4_infa_reg   <= f3_infa_reg;
            f4_infb_reg   <= f3_infb_reg;
        end
    end

    // ---------------- stage 5: mass products, divisor and mass-case flags
    logic               f4_fin;
    logic [23:0]        f4_numa;
    logic signed [60:0] f5_prod_a_reg, f5_prod_b_reg;
    logic [55:0]        f5_xsx_reg, f5_xsy_reg;
    logic signed [35:0] f5_pa_reg, f5_pb_reg;
    logic [24:0]        f5_den_reg;
    logic               f5_fin_reg, f5_infa_reg, f5_infb_reg;
    logic               f5_kill_all_reg, f5_kill_shift_reg;
    logic [31:0]        f5_tx_reg, f5_ty_reg;
    logic               f5_ax_neg_reg, f5_ay_neg_reg;
    logic [15:0]        f5_ax_mag_reg, f5_ay_mag_reg;

    assign f4_fin  = !f4_infa_reg && !f4_infb_reg;
    assign f4_numa = f4_fin ? f4_mb_reg : (f4_infb_reg && !f4_infa_reg) ? 24'd1 : 24'd0;

    always_ff @(posedge aclk) begin
        if (stg_rdy[4]) begin
            f5_prod_a_reg     <= 61'($signed({1'b0, f4_ma_reg})) * 61'(f4_d_reg);
            f5_prod_b_reg     <= 61'($signed({1'b0, f4_mb_reg})) * 61'(f4_d_reg);
            f5_xsx_reg        <= 56'(f4_tx_reg) * 56'(f4_numa);
            f5_xsy_reg        <= 56'(f4_ty_reg) * 56'(f4_numa);
            f5_pa_reg         <= f4_pa_reg;
            f5_pb_reg         <= f4_pb_reg;
            f5_den_reg        <= (f4_fin && f4_msum_reg != '0) ? f4_msum_reg : 25'd1;
            f5_fin_reg        <= f4_fin;
            f5_infa_reg       <= f4_infa_reg;
            f5_infb_reg       <= f4_infb_reg;
            f5_kill_all_reg   <= f4_fin && (f4_msum_reg == '0);
            f5_kill_shift_reg <= f4_infa_reg && f4_infb_reg;
            f5_tx_reg         <= f4_tx_reg;
            f5_ty_reg         <= f4_ty_reg;
            f5_ax_neg_reg     <= f4_ax_neg_reg;
            f5_ay_neg_reg     <= f4_ay_neg_reg;
            f5_ax_mag_reg     <= f4_ax_mag_reg;
            f5_ay_mag_reg     <= f4_ay_mag_reg;
        end
    end

    // ---------------- stage 6: signed numerators, rounding bias, divider load
    // lanes: 0 velocity A, 1 velocity B, 2 displacement x, 3 displacement y
    logic signed [61:0] f6_xa, f6_xb;
    logic [61:0]        f6_ma, f6_mb;
    logic [DW-1:0]      dnq_reg  [0:DW][0:3];
    logic [ecr_pkg::DEN_W-1:0] drem_reg [0:DW][0:3];
    ecr_pkg::ecr_ctx_t  ctx_reg  [0:DW];

    always_comb begin
        if (f5_fin_reg) begin
            f6_xa = -(62'(f5_prod_b_reg) <<< 1);
            f6_xb = 62'(f5_prod_a_reg) <<< 1;
        end else begin
            f6_xa = (f5_infb_reg && !f5_infa_reg) ? -(62'(f5_pa_reg) <<< 1) : '0;
            f6_xb = (f5_infa_reg && !f5_infb_reg) ? -(62'(f5_pb_reg) <<< 1) : '0;
        end
        f6_ma = f6_xa[61] ? 62'(-f6_xa) : 62'(f6_xa);
        f6_mb = f6_xb[61] ? 62'(-f6_xb) : 62'(f6_xb);
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[DB]) begin
            dnq_reg[0][0]          <= f6_ma[DW-1:0] + DW'(f5_den_reg[24:1]);
            dnq_reg[0][1]          <= f6_mb[DW-1:0] + DW'(f5_den_reg[24:1]);
            dnq_reg[0][2]          <= DW'(f5_xsx_reg);
            dnq_reg[0][3]          <= DW'(f5_xsy_reg);
            drem_reg[0][0]         <= '0;
            drem_reg[0][1]         <= '0;
            drem_reg[0][2]         <= '0;
            drem_reg[0][3]         <= '0;
            ctx_reg[0].den         <= f5_den_reg;
            ctx_reg[0].ax_mag      <= f5_ax_mag_reg;
            ctx_reg[0].ay_mag      <= f5_ay_mag_reg;
            ctx_reg[0].ax_neg      <= f5_ax_neg_reg;
            ctx_reg[0].ay_neg      <= f5_ay_neg_reg;
            ctx_reg[0].va_neg      <= f6_xa[61];
            ctx_reg[0].vb_neg      <= f6_xb[61];
            ctx_reg[0].tx          <= f5_tx_reg;
            ctx_reg[0].ty          <= f5_ty_reg;
            ctx_reg[0].kill_all    <= f5_kill_all_reg;
            ctx_reg[0].kill_shift  <= f5_kill_shift_reg;
        end
    end

    // ---------------- divider: one restoring step per stage, four lanes
    for (genvar k = 1; k <= DW; k++) begin : g_div
        for (genvar l = 0; l < 4; l++) begin : g_lane
            logic [ecr_pkg::DEN_W:0] trial;
            logic                    ge;

            assign trial = {drem_reg[k-1][l], dnq_reg[k-1][l][DW-1]};
            assign ge    = (trial >= {1'b0, ctx_reg[k-1].den});

            always_ff @(posedge aclk) begin
                if (stg_rdy[DB+k]) begin
                    drem_reg[k][l] <= ge ? ecr_pkg::DEN_W'(trial - {1'b0, ctx_reg[k-1].den})
                                         : trial[ecr_pkg::DEN_W-1:0];
                    dnq_reg[k][l]  <= {dnq_reg[k-1][l][DW-2:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_rdy[DB+k]) begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // ---------------- back stage 1: clamp, scale by normal, complementary share
    logic [46:0]       p1_da, p1_db;
    logic [62:0]       p1_dax_reg, p1_day_reg, p1_dbx_reg, p1_dby_reg;
    logic [31:0]       p1_qax_reg, p1_qay_reg, p1_qbx_reg, p1_qby_reg;
    ecr_pkg::ecr_ctx_t p1_ctx_reg;

    assign p1_da = (dnq_reg[DW][0] > DW'(ecr_pkg::DA_CLAMP)) ? ecr_pkg::DA_CLAMP
                                                              : dnq_reg[DW][0][46:0];
    assign p1_db = (dnq_reg[DW][1] > DW'(ecr_pkg::DA_CLAMP)) ? ecr_pkg::DA_CLAMP
                                                              : dnq_reg[DW][1][46:0];

    always_ff @(posedge aclk) begin
        if (stg_rdy[ecr_pkg::P1_IDX]) begin
            p1_dax_reg <= 63'(p1_da) * 63'(ctx_reg[DW].ax_mag);
            p1_day_reg <= 63'(p1_da) * 63'(ctx_reg[DW].ay_mag);
            p1_dbx_reg <= 63'(p1_db) * 63'(ctx_reg[DW].ax_mag);
            p1_dby_reg <= 63'(p1_db) * 63'(ctx_reg[DW].ay_mag);
            p1_qax_reg <= dnq_reg[DW][2][31:0];
            p1_qay_reg <= dnq_reg[DW][3][31:0];
            p1_qbx_reg <= ctx_reg[DW].tx - dnq_reg[DW][2][31:0]
                          - 32'(drem_reg[DW][2] != '0);
            p1_qby_reg <= ctx_reg[DW].ty - dnq_reg[DW][3][31:0]
                          - 32'(drem_reg[DW][3] != '0);
            p1_ctx_reg <= ctx_reg[DW];
        end
    end

    // ---------------- back stage 2: output register
    logic [31:0] o_dax_reg, o_day_reg, o_dbx_reg, o_dby_reg;
    logic [31:0] o_sax_reg, o_say_reg, o_sbx_reg, o_sby_reg;
    logic        p1_ks;

    assign p1_ks = p1_ctx_reg.kill_all || p1_ctx_reg.kill_shift;

    always_ff @(posedge aclk) begin
        if (stg_rdy[ecr_pkg::OUT_IDX]) begin
            o_dax_reg <= ecr_pkg::ecr_dvel(p1_dax_reg, p1_ctx_reg.va_neg ^ p1_ctx_reg.ax_neg,
                                           p1_ctx_reg.kill_all);
            o_day_reg <= ecr_pkg::ecr_dvel(p1_day_reg, p1_ctx_reg.va_neg ^ p1_ctx_reg.ay_neg,
                                           p1_ctx_reg.kill_all);
            o_dbx_reg <= ecr_pkg::ecr_dvel(p1_dbx_reg, p1_ctx_reg.vb_neg ^ p1_ctx_reg.ax_neg,
                                           p1_ctx_reg.kill_all);
            o_dby_reg <= ecr_pkg::ecr_dvel(p1_dby_reg, p1_ctx_reg.vb_neg ^ p1_ctx_reg.ay_neg,
                                           p1_ctx_reg.kill_all);
            o_sax_reg <= ecr_pkg::ecr_shift(p1_qax_reg, p1_ctx_reg.ax_neg, p1_ks);
            o_say_reg <= ecr_pkg::ecr_shift(p1_qay_reg, p1_ctx_reg.ay_neg, p1_ks);
            o_sbx_reg <= ecr_pkg::ecr_shift(p1_qbx_reg, !p1_ctx_reg.ax_neg, p1_ks);
            o_sby_reg <= ecr_pkg::ecr_shift(p1_qby_reg, !p1_ctx_reg.ay_neg, p1_ks);
        end
    end

    assign m_dvel_a_x  = $signed(o_dax_reg);
    assign m_dvel_a_y  = $signed(o_day_reg);
    assign m_dvel_b_x  = $signed(o_dbx_reg);
    assign m_dvel_b_y  = $signed(o_dby_reg);
    assign m_shift_a_x = $signed(o_sax_reg);
    assign m_shift_a_y = $signed(o_say_reg);
    assign m_shift_b_x = $signed(o_sbx_reg);
    assign m_shift_b_y = $signed(o_sby_reg);

    // ---------------- checks
    // divider leaves a proper remainder on the x displacement lane
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[DB+DW] |-> (drem_reg[DW][2] < ctx_reg[DW].den))
        else $error("divider remainder not below divisor");

    // x mass share never exceeds the full depth, so the complement is never negative
    a_share_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[DB+DW] |-> (dnq_reg[DW][2] <= DW'(ctx_reg[DW].tx)))
        else $error("displacement share above full depth");

    // a stalled item at the divider load is held, not dropped
    a_load_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[DB] && !stg_rdy[DB+1]) |=> v_reg[DB])
        else $error("item lost at divider load");

    // A x and B y displacements stay within one unit past the Q.16 integer range
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_shift_a_x <= 32'sd65536 && m_shift_a_x >= -32'sd65536)
                  && (m_shift_b_y <= 32'sd65536 && m_shift_b_y >= -32'sd65536)))
        else $error("displacement out of range");

endmodule

`default_nettype wire
